// ===== rtl/stok_pkg.sv =====
package stok_pkg;

   localparam int LineBits   = 20;
   localparam int ColumnBits = 16;
   localparam int OffsetBits = 24;
   localparam int KindBits   = 6;
   localparam int MaxRes     = 4;
   localparam int SlotBits   = 2;

   localparam logic [KindBits-1:0] K_LBRACE = 6'd15;
   localparam logic [KindBits-1:0] K_COMMA  = 6'd19;
   localparam logic [KindBits-1:0] K_SEMI   = 6'd20;
   localparam logic [KindBits-1:0] K_IDENT  = 6'd37;
   localparam logic [KindBits-1:0] K_INT    = 6'd38;
   localparam logic [KindBits-1:0] K_FLOAT  = 6'd39;
   localparam logic [KindBits-1:0] K_TRUE   = 6'd40;
   localparam logic [KindBits-1:0] K_FALSE  = 6'd41;
   localparam logic [KindBits-1:0] K_STR    = 6'd42;
   localparam logic [KindBits-1:0] K_EOF    = 6'd43;
   localparam logic [KindBits-1:0] K_ERR    = 6'd44;
   localparam logic [KindBits-1:0] K_NONE   = 6'd63;

   typedef enum logic [3:0] {
      M_IDLE, M_COMMENT, M_OP, M_STRING, M_IDENT, M_ZERO, M_HEX, M_INT, M_FRAC
   } mode_type;

   typedef struct packed {
      logic [KindBits-1:0]   kind;
      logic [LineBits-1:0]   line;
      logic [ColumnBits-1:0] column;
      logic [OffsetBits-1:0] offset;
      logic [OffsetBits-1:0] length;
   } token_type;

   // Tokens caused by one byte, packed to the low slots
   typedef struct packed {
      logic [SlotBits:0]          count;
      token_type [MaxRes-1:0]     tok;
   } bundle_type;

   function automatic logic is_num(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_hexch(input logic [7:0] c);
      return is_num(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic op_first(input logic [7:0] c);
      return c == ":" || c == ">" || c == "=" || c == "!" || c == "<" || c == "&"
         || c == "|";
   endfunction

   function automatic logic [KindBits-1:0] one_kind(input logic [7:0] c);
      logic [KindBits-1:0] k;
      case (c)
         "#": k = 6'd0;   "@": k = 6'd1;   "?": k = 6'd2;   ":": k = 6'd3;
         8'h5c: k = 6'd4; "!": k = 6'd5;   "&": k = 6'd6;   "^": k = 6'd7;
         "~": k = 6'd8;   "%": k = 6'd9;   "|": k = 6'd10;  "(": k = 6'd13;
         ")": k = 6'd14;  "{": k = 6'd15;  "}": k = 6'd16;  "[": k = 6'd17;
         "]": k = 6'd18;  ",": k = 6'd19;  ";": k = 6'd20;  "+": k = 6'd21;
         "-": k = 6'd22;  "*": k = 6'd23;  "/": k = 6'd24;  "=": k = 6'd25;
         "<": k = 6'd28;  ">": k = 6'd29;  ".": k = 6'd35;  "$": k = 6'd36;
         default: k = K_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [KindBits-1:0] pair_kind(input logic [7:0] a,
                                                     input logic [7:0] b);
      logic [KindBits-1:0] k;
      k = K_NONE;
      if (a == ":" && b == "=") k = 6'd34;
      if (a == ">" && b == ">") k = 6'd11;
      if (a == "=" && b == "=") k = 6'd26;
      if (a == "!" && b == "=") k = 6'd27;
      if (a == "<" && b == "=") k = 6'd30;
      if (a == ">" && b == "=") k = 6'd31;
      if (a == "&" && b == "&") k = 6'd32;
      if (a == "|" && b == "|") k = 6'd33;
      if (a == "<" && b == "<") k = 6'd12;
      return k;
   endfunction

endpackage

// ===== rtl/stok_front.sv =====
module stok_front import stok_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [7:0]       in_byte,
   input  logic             in_final,
   output logic             in_stall,
   output logic             push,
   output bundle_type       push_data,
   input  logic             queue_full
);

   mode_type              mode_ff, mode_in;
   logic [LineBits-1:0]   line_ff, line_in, sline_ff, sline_in;
   logic [ColumnBits-1:0] col_ff, col_in, scol_ff, scol_in;
   logic [OffsetBits-1:0] off_ff, off_in, soff_ff, soff_in;
   logic [7:0]            held_ff, held_in;
   logic                  nl_ff, nl_in, any_ff, any_in, esc_ff, esc_in, halt_ff, halt_in;
   logic [KindBits-1:0]   prev_ff, prev_in;

   assign in_stall = queue_full;
   wire take = in_valid && !queue_full;

   // Classify one byte against the scan state and collect its tokens
   always_comb begin
      logic [7:0]            c;
      logic [OffsetBits-1:0] cur, len;
      logic [KindBits-1:0]   k;
      logic                  redo, fin_tok;
      bundle_type            b;
      c = in_byte;
      b = '0;
      mode_in = mode_ff; line_in = line_ff; col_in = col_ff; off_in = off_ff;
      sline_in = sline_ff; scol_in = scol_ff; soff_in = soff_ff; held_in = held_ff;
      nl_in = nl_ff; any_in = any_ff; esc_in = esc_ff; halt_in = halt_ff;
      prev_in = prev_ff;
      cur = off_ff;
      redo = 1'b0; fin_tok = 1'b0;
      len = '0; k = K_NONE;
      if (!halt_ff) begin
         off_in = (off_ff == '1) ? off_ff : off_ff + 1'b1;
         // Continue the current token
         case (mode_ff)
            M_COMMENT: redo = (c == 8'h0a);
            M_OP: begin
               k = pair_kind(held_ff, c);
               if (k != K_NONE) begin
                  b.tok[b.count[SlotBits-1:0]] = '{k, sline_ff, scol_ff, soff_ff, 24'd2};
                  b.count = b.count + 1'b1; prev_in = k; any_in = 1'b1;
                  col_in = (col_in == '1) ? col_in : col_in + 1'b1;
                  mode_in = M_IDLE;
               end else if (held_ff == "/" && c == "/") begin
                  col_in = scol_ff; mode_in = M_COMMENT;
               end else begin
                  fin_tok = 1'b1; redo = 1'b1;
               end
            end
            M_STRING: begin
               col_in = (col_in == '1) ? col_in : col_in + 1'b1;
               if (esc_ff) esc_in = 1'b0;
               else if (c == 8'h5c) esc_in = 1'b1;
               else if (c == 8'h22) fin_tok = 1'b1;
            end
            M_IDENT: begin
               if (is_alpha(c) || is_num(c))
                  col_in = (col_in == '1) ? col_in : col_in + 1'b1;
               else begin fin_tok = 1'b1; redo = 1'b1; end
            end
            M_ZERO: begin
               if (c == "x" || c == "X") mode_in = M_HEX;
               else if (is_num(c)) mode_in = M_INT;
               else if (c == ".") mode_in = M_FRAC;
               else begin fin_tok = 1'b1; redo = 1'b1; end
               if (!redo) col_in = (col_in == '1) ? col_in : col_in + 1'b1;
            end
            M_HEX: begin
               if (is_hexch(c)) col_in = (col_in == '1) ? col_in : col_in + 1'b1;
               else begin fin_tok = 1'b1; redo = 1'b1; end
            end
            M_INT: begin
               if (is_num(c)) col_in = (col_in == '1) ? col_in : col_in + 1'b1;
               else if (c == ".") begin
                  mode_in = M_FRAC; col_in = (col_in == '1) ? col_in : col_in + 1'b1;
               end else begin fin_tok = 1'b1; redo = 1'b1; end
            end
            M_FRAC: begin
               if (is_num(c)) col_in = (col_in == '1) ? col_in : col_in + 1'b1;
               else begin fin_tok = 1'b1; redo = 1'b1; end
            end
            default: redo = 1'b1;
         endcase
         // Close the open token
         if (fin_tok) begin
            len = cur - soff_ff; k = K_NONE;
            case (mode_ff)
               M_OP: begin
                  if (held_ff == "/") begin
                     if (nl_in && any_in && prev_in != K_SEMI && prev_in != K_LBRACE
                         && prev_in != K_COMMA) begin
                        b.tok[b.count[SlotBits-1:0]] = '{K_SEMI, sline_ff, scol_ff, soff_ff, '0};
                        b.count = b.count + 1'b1; prev_in = K_SEMI; any_in = 1'b1;
                     end
                     nl_in = 1'b0;
                  end
                  k = one_kind(held_ff); len = 24'd1;
               end
               M_STRING: k = K_STR;
               M_IDENT: begin
                  k = K_IDENT;
                  if (len == 24'd1 && held_ff == "T") k = K_TRUE;
                  if (len == 24'd1 && held_ff == "F") k = K_FALSE;
               end
               M_ZERO, M_HEX, M_INT: k = K_INT;
               M_FRAC: k = K_FLOAT;
               default: k = K_NONE;
            endcase
            if (k != K_NONE) begin
               b.tok[b.count[SlotBits-1:0]] = '{k, sline_ff, scol_ff, soff_ff, len};
               b.count = b.count + 1'b1; prev_in = k; any_in = 1'b1;
            end
            mode_in = M_IDLE;
         end
         // Start a new token from this byte
         if (redo) begin
            mode_in = M_IDLE;
            if (c == " " || c == 8'h09 || c == 8'h0d)
               col_in = (col_in == '1) ? col_in : col_in + 1'b1;
            else if (c == 8'h0a) begin
               line_in = (line_in == '1) ? line_in : line_in + 1'b1;
               col_in = ColumnBits'(1); nl_in = 1'b1;
            end else begin
               sline_in = line_in; scol_in = col_in; soff_in = cur;
               if (c == "/") begin
                  held_in = c; mode_in = M_OP;
                  col_in = (col_in == '1) ? col_in : col_in + 1'b1;
               end else begin
                  if (nl_in && any_in && prev_in != K_SEMI && prev_in != K_LBRACE
                      && prev_in != K_COMMA) begin
                     b.tok[b.count[SlotBits-1:0]] = '{K_SEMI, line_in, col_in, cur, '0};
                     b.count = b.count + 1'b1; prev_in = K_SEMI; any_in = 1'b1;
                  end
                  nl_in = 1'b0;
                  k = one_kind(c);
                  if (op_first(c)) begin
                     held_in = c; mode_in = M_OP;
                     col_in = (col_in == '1) ? col_in : col_in + 1'b1;
                  end else if (k != K_NONE) begin
                     b.tok[b.count[SlotBits-1:0]] = '{k, line_in, col_in, cur, 24'd1};
                     b.count = b.count + 1'b1; prev_in = k; any_in = 1'b1;
                     col_in = (col_in == '1) ? col_in : col_in + 1'b1;
                  end else if (c == 8'h22) begin
                     mode_in = M_STRING; esc_in = 1'b0;
                     soff_in = (cur == '1) ? cur : cur + 1'b1;
                     col_in = (col_in == '1) ? col_in : col_in + 1'b1;
                  end else if (is_alpha(c)) begin
                     held_in = c; mode_in = M_IDENT;
                     col_in = (col_in == '1) ? col_in : col_in + 1'b1;
                  end else if (is_num(c)) begin
                     mode_in = (c == "0") ? M_ZERO : M_INT;
                     col_in = (col_in == '1) ? col_in : col_in + 1'b1;
                  end else begin
                     b.tok[b.count[SlotBits-1:0]] = '{K_ERR, line_in, col_in, cur, 24'd1};
                     b.count = b.count + 1'b1; prev_in = K_ERR; any_in = 1'b1;
                     halt_in = 1'b1;
                  end
               end
            end
         end
         // End of source: flush, semicolon, EOF, then clear
         if (!halt_in && in_final) begin
            len = off_in - soff_in; k = K_NONE;
            case (mode_in)
               M_OP: begin
                  if (held_in == "/") begin
                     if (nl_in && any_in && prev_in != K_SEMI && prev_in != K_LBRACE
                         && prev_in != K_COMMA) begin
                        b.tok[b.count[SlotBits-1:0]] = '{K_SEMI, sline_in, scol_in, soff_in, '0};
                        b.count = b.count + 1'b1; prev_in = K_SEMI; any_in = 1'b1;
                     end
                     nl_in = 1'b0;
                  end
                  k = one_kind(held_in); len = 24'd1;
               end
               M_STRING: k = K_STR;
               M_IDENT: begin
                  k = K_IDENT;
                  if (len == 24'd1 && held_in == "T") k = K_TRUE;
                  if (len == 24'd1 && held_in == "F") k = K_FALSE;
               end
               M_ZERO, M_HEX, M_INT: k = K_INT;
               M_FRAC: k = K_FLOAT;
               default: k = K_NONE;
            endcase
            if (k != K_NONE) begin
               b.tok[b.count[SlotBits-1:0]] = '{k, sline_in, scol_in, soff_in, len};
               b.count = b.count + 1'b1; prev_in = k; any_in = 1'b1;
            end
            if (nl_in && any_in && prev_in != K_SEMI && prev_in != K_LBRACE
                && prev_in != K_COMMA && b.count < MaxRes) begin
               b.tok[b.count[SlotBits-1:0]] = '{K_SEMI, line_in, col_in, off_in, '0};
               b.count = b.count + 1'b1;
            end
            if (b.count < MaxRes) begin
               b.tok[b.count[SlotBits-1:0]] = '{K_EOF, line_in, col_in, off_in, '0};
               b.count = b.count + 1'b1;
            end
            mode_in = M_IDLE; line_in = LineBits'(1); col_in = ColumnBits'(1);
            off_in = '0; soff_in = '0;
            sline_in = LineBits'(1); scol_in = ColumnBits'(1); held_in = '0; prev_in = '0;
            nl_in = 1'b0; any_in = 1'b0; esc_in = 1'b0;
         end
      end
      push_data = b;
   end

   assign push = take && (push_data.count != '0);

   // Advance scan state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE; line_ff <= LineBits'(1); col_ff <= ColumnBits'(1);
         off_ff <= '0;
         sline_ff <= LineBits'(1); scol_ff <= ColumnBits'(1); soff_ff <= '0;
         held_ff <= '0;
         nl_ff <= 1'b0; any_ff <= 1'b0; esc_ff <= 1'b0; halt_ff <= 1'b0;
         prev_ff <= '0;
      end else if (take) begin
         mode_ff <= mode_in; line_ff <= line_in; col_ff <= col_in; off_ff <= off_in;
         sline_ff <= sline_in; scol_ff <= scol_in; soff_ff <= soff_in;
         held_ff <= held_in; nl_ff <= nl_in; any_ff <= any_in; esc_ff <= esc_in;
         halt_ff <= halt_in; prev_ff <= prev_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) halt_ff |-> !push)
      else $error("token pushed while halted");
   assert property (@(posedge clock) disable iff (reset) push |-> push_data.count <= MaxRes)
      else $error("bundle overflow");
   assert property (@(posedge clock) disable iff (reset)
      (take && in_final && !halt_ff) |=> (halt_ff || (mode_ff == M_IDLE && off_ff == '0)))
      else $error("state not cleared after end of source");

endmodule

// ===== rtl/stok_queue.sv =====
module stok_queue import stok_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_data,
   output logic       full,
   output logic       head_valid,
   output bundle_type head_data,
   input  logic       pop
);

   bundle_type mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   assign full       = (cnt_ff == 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head_data  = mem_ff[rd_ff];

   // Hold bundles between front and back
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0; rd_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) !(pop && !head_valid))
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count out of range");

endmodule

// ===== rtl/stok_back.sv =====
module stok_back import stok_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  bundle_type head_data,
   output logic       pop,
   output logic       out_valid,
   output token_type  out_tok,
   output logic       out_last,
   input  logic       out_stall
);

   logic [SlotBits-1:0] idx_ff;
   logic                last;

   assign last      = ({1'b0, idx_ff} + 1'b1) == head_data.count;
   assign out_valid = head_valid;
   assign out_tok   = head_data.tok[idx_ff];
   assign out_last  = last;
   assign pop       = head_valid && !out_stall && last;

   // Step through the tokens of the head bundle
   always_ff @(posedge clock) begin
      if (reset) idx_ff <= '0;
      else if (head_valid && !out_stall) idx_ff <= last ? '0 : idx_ff + 1'b1;
   end

   assert property (@(posedge clock) disable iff (reset)
      head_valid |-> {1'b0, idx_ff} < head_data.count)
      else $error("slot index past bundle");
   assert property (@(posedge clock) disable iff (reset) !head_valid |-> idx_ff == '0)
      else $error("index not at start while empty");
   assert property (@(posedge clock) disable iff (reset) pop |=> idx_ff == '0)
      else $error("index not reset after bundle");

endmodule

// ===== rtl/source_tokenizer.sv =====
// Path: a byte's tokens are written into the queue when the byte is taken and shown from its head.
// Throughput: one byte per cycle while the queue is not full; a byte that yields n tokens
// has them shown one at a time by the single result port draining a 2-deep queue.
// Reset: synchronous, active high; the scan state returns to line 1, column 1,
// offset 0, and a halt after a lex error is cleared only by reset.
module source_tokenizer import stok_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_source_byte,
   input  logic                  req_final_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [KindBits-1:0]   rsp_token_kind,
   output logic [LineBits-1:0]   rsp_start_line,
   output logic [ColumnBits-1:0] rsp_start_column,
   output logic [OffsetBits-1:0] rsp_text_offset,
   output logic [OffsetBits-1:0] rsp_text_length,
   output logic                  rsp_last_of_run
);

   logic       push, full, head_valid, pop;
   bundle_type push_data, head_data;
   token_type  tok;

   stok_front u_front (
      .clock, .reset, .in_valid(req_valid), .in_byte(req_source_byte),
      .in_final(req_final_byte), .in_stall(req_stall), .push, .push_data,
      .queue_full(full)
   );

   stok_queue u_queue (
      .clock, .reset, .push, .push_data, .full, .head_valid, .head_data, .pop
   );

   stok_back u_back (
      .clock, .reset, .head_valid, .head_data, .pop, .out_valid(rsp_valid),
      .out_tok(tok), .out_last(rsp_last_of_run), .out_stall(rsp_stall)
   );

   assign rsp_token_kind   = tok.kind;
   assign rsp_start_line   = tok.line;
   assign rsp_start_column = tok.column;
   assign rsp_text_offset  = tok.offset;
   assign rsp_text_length  = tok.length;

endmodule

// ===== tb/source_tokenizer_tb.sv =====
module source_tokenizer_tb import stok_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 400000;
   localparam int ByteTarget = 260;

   typedef enum logic [5:0] {
      KD_HASH, KD_AT, KD_QUERY, KD_COLON, KD_BSLASH, KD_BANG, KD_AMP, KD_CARET,
      KD_TILDE, KD_PCT, KD_BAR, KD_SHR, KD_SHL, KD_LPAREN, KD_RPAREN, KD_LBRACE,
      KD_RBRACE, KD_LBRACK, KD_RBRACK, KD_COMMA, KD_SEMI, KD_PLUS, KD_MINUS,
      KD_STAR, KD_SLASH, KD_ASSIGN, KD_EQ, KD_NE, KD_LT, KD_GT, KD_LE, KD_GE,
      KD_ANDAND, KD_OROR, KD_DEFINE, KD_DOT, KD_DOLLAR, KD_IDENT, KD_INT,
      KD_FLOAT, KD_TRUE, KD_FALSE, KD_STR, KD_EOF, KD_ERR, KD_NONE = 6'd63
   } tok_kind_type;

   typedef struct {
      logic [KindBits-1:0]   kind;
      logic [LineBits-1:0]   line;
      logic [ColumnBits-1:0] column;
      logic [OffsetBits-1:0] offset;
      logic [OffsetBits-1:0] length;
      logic                  last;
   } exp_token_type;

   class token_scoreboard;
      exp_token_type expected_tokens[$];
      exp_token_type run[$];
      int         errors;
      int         tokens_checked;
      mode_type   mode;
      int unsigned line_no, col_no, offs, ts_off, ts_line, ts_col;
      logic [7:0] held;
      tok_kind_type prev;
      bit         nl, any, esc, halted;

      function new();
         clear();
         errors = 0;
         tokens_checked = 0;
      endfunction

      function void clear();
         mode = M_IDLE;
         line_no = 1; col_no = 1; offs = 0;
         ts_off = 0; ts_line = 1; ts_col = 1;
         held = 0; prev = KD_HASH;
         nl = 0; any = 0; esc = 0; halted = 0;
      endfunction

      function int unsigned sat(int unsigned v, int bits);
         longint unsigned top;
         top = (64'd1 << bits) - 1;
         return (v < top) ? v + 1 : int'(top);
      endfunction

      function bit is_num(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function bit is_alpha(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
      endfunction

      function bit is_hex(logic [7:0] c);
         return is_num(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
      endfunction

      function bit pair_lead(logic [7:0] c);
         return c == ":" || c == ">" || c == "=" || c == "!" || c == "<" ||
                c == "&" || c == "|";
      endfunction

      function tok_kind_type single_kind(logic [7:0] c);
         case (c)
            "#": return KD_HASH;    "@": return KD_AT;      "?": return KD_QUERY;
            ":": return KD_COLON;   "\\": return KD_BSLASH; "!": return KD_BANG;
            "&": return KD_AMP;     "^": return KD_CARET;   "~": return KD_TILDE;
            "%": return KD_PCT;     "|": return KD_BAR;     "(": return KD_LPAREN;
            ")": return KD_RPAREN;  "{": return KD_LBRACE;  "}": return KD_RBRACE;
            "[": return KD_LBRACK;  "]": return KD_RBRACK;  ",": return KD_COMMA;
            ";": return KD_SEMI;    "+": return KD_PLUS;    "-": return KD_MINUS;
            "*": return KD_STAR;    "/": return KD_SLASH;   "=": return KD_ASSIGN;
            "<": return KD_LT;      ">": return KD_GT;      ".": return KD_DOT;
            "$": return KD_DOLLAR;
            default: return KD_NONE;
         endcase
      endfunction

      function tok_kind_type pair_code(logic [7:0] a, logic [7:0] b);
         if (a == ":" && b == "=") return KD_DEFINE;
         if (a == ">" && b == ">") return KD_SHR;
         if (a == "=" && b == "=") return KD_EQ;
         if (a == "!" && b == "=") return KD_NE;
         if (a == "<" && b == "=") return KD_LE;
         if (a == ">" && b == "=") return KD_GE;
         if (a == "&" && b == "&") return KD_ANDAND;
         if (a == "|" && b == "|") return KD_OROR;
         if (a == "<" && b == "<") return KD_SHL;
         return KD_NONE;
      endfunction

      function void emit(tok_kind_type k, int unsigned ln, int unsigned cl,
                         int unsigned off, int unsigned len);
         exp_token_type t;
         t.kind = k; t.line = ln[LineBits-1:0]; t.column = cl[ColumnBits-1:0];
         t.offset = off[OffsetBits-1:0]; t.length = len[OffsetBits-1:0];
         t.last = 0;
         if (run.size() < MaxRes) run.push_back(t);
         prev = k;
         any = 1;
      endfunction

      // Insert a semicolon after a newline unless the last token closes a statement
      function void auto_semi(int unsigned ln, int unsigned cl, int unsigned off);
         if (nl && any && prev != KD_SEMI && prev != KD_LBRACE && prev != KD_COMMA)
            emit(KD_SEMI, ln, cl, off, 0);
      endfunction

      function void close_token(int unsigned cur);
         int unsigned len;
         tok_kind_type k;
         len = cur - ts_off;
         k = KD_NONE;
         case (mode)
            M_OP: begin
               if (held == "/") begin
                  auto_semi(ts_line, ts_col, ts_off);
                  nl = 0;
               end
               k = single_kind(held);
               len = 1;
            end
            M_STRING: k = KD_STR;
            M_IDENT: begin
               k = KD_IDENT;
               if (len == 1 && held == "T") k = KD_TRUE;
               if (len == 1 && held == "F") k = KD_FALSE;
            end
            M_ZERO, M_HEX, M_INT: k = KD_INT;
            M_FRAC: k = KD_FLOAT;
            default: ;
         endcase
         if (k != KD_NONE) emit(k, ts_line, ts_col, ts_off, len);
         mode = M_IDLE;
      endfunction

      // Start scanning from the idle state
      function void start_byte(logic [7:0] c, int unsigned off);
         tok_kind_type k;
         mode = M_IDLE;
         if (c == " " || c == "\t" || c == 8'h0d) begin
            col_no = sat(col_no, ColumnBits);
            return;
         end
         if (c == "\n") begin
            line_no = sat(line_no, LineBits);
            col_no = 1;
            nl = 1;
            return;
         end
         ts_line = line_no; ts_col = col_no; ts_off = off;
         if (c == "/") begin
            held = c; mode = M_OP; col_no = sat(col_no, ColumnBits);
            return;
         end
         auto_semi(line_no, col_no, off);
         nl = 0;
         if (pair_lead(c)) begin
            held = c; mode = M_OP; col_no = sat(col_no, ColumnBits);
            return;
         end
         k = single_kind(c);
         if (k != KD_NONE) begin
            emit(k, line_no, col_no, off, 1);
            col_no = sat(col_no, ColumnBits);
            return;
         end
         if (c == "\"") begin
            mode = M_STRING; esc = 0;
            ts_off = sat(off, OffsetBits);
            col_no = sat(col_no, ColumnBits);
            return;
         end
         if (is_alpha(c)) begin
            held = c; mode = M_IDENT; col_no = sat(col_no, ColumnBits);
            return;
         end
         if (is_num(c)) begin
            mode = (c == "0") ? M_ZERO : M_INT;
            col_no = sat(col_no, ColumnBits);
            return;
         end
         emit(KD_ERR, line_no, col_no, off, 1);
         halted = 1;
      endfunction

      // Advance the scan by one byte; return 1 if the byte extends the token
      function bit extend(logic [7:0] c);
         case (mode)
            M_IDENT: return is_alpha(c) || is_num(c);
            M_HEX:   return is_hex(c);
            M_FRAC:  return is_num(c);
            M_INT: begin
               if (c == ".") mode = M_FRAC;
               return is_num(c) || c == ".";
            end
            M_ZERO: begin
               if (c == "x" || c == "X") mode = M_HEX;
               else if (is_num(c)) mode = M_INT;
               else if (c == ".") mode = M_FRAC;
               return c == "x" || c == "X" || is_num(c) || c == ".";
            end
            default: return 0;
         endcase
      endfunction

      function void scan_byte(logic [7:0] c, int unsigned off);
         tok_kind_type k;
         case (mode)
            M_IDLE: start_byte(c, off);
            M_COMMENT: if (c == "\n") start_byte(c, off);
            M_OP: begin
               k = pair_code(held, c);
               if (k != KD_NONE) begin
                  emit(k, ts_line, ts_col, ts_off, 2);
                  col_no = sat(col_no, ColumnBits);
                  mode = M_IDLE;
               end else if (held == "/" && c == "/") begin
                  col_no = ts_col;
                  mode = M_COMMENT;
               end else begin
                  close_token(off);
                  start_byte(c, off);
               end
            end
            M_STRING: begin
               col_no = sat(col_no, ColumnBits);
               if (esc) esc = 0;
               else if (c == "\\") esc = 1;
               else if (c == "\"") close_token(off);
            end
            default: begin
               if (extend(c)) col_no = sat(col_no, ColumnBits);
               else begin
                  close_token(off);
                  start_byte(c, off);
               end
            end
         endcase
      endfunction

      // Predict the tokens for one accepted byte
      function void note_byte(logic [7:0] c, logic fin);
         int unsigned off;
         run.delete();
         if (halted) return;
         off = offs;
         offs = sat(offs, OffsetBits);
         scan_byte(c, off);
         if (!halted && fin) begin
            close_token(offs);
            auto_semi(line_no, col_no, offs);
            emit(KD_EOF, line_no, col_no, offs, 0);
            clear();
         end
         if (run.size() > 0) run[run.size()-1].last = 1;
         foreach (run[i]) expected_tokens.push_back(run[i]);
      endfunction

      function void field(string name, longint unsigned e, longint unsigned a);
         if (e != a) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
         end
      endfunction

      function void check_token(exp_token_type got);
         exp_token_type w;
         if (expected_tokens.size() == 0) begin
            errors++;
            $display("%0t: unexpected token, expected none, actual kind %0d",
                     $time, got.kind);
            return;
         end
         w = expected_tokens.pop_front();
         tokens_checked++;
         field("kind", w.kind, got.kind);
         field("line", w.line, got.line);
         field("column", w.column, got.column);
         field("offset", w.offset, got.offset);
         field("length", w.length, got.length);
         field("last_of_run", w.last, got.last);
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_source_byte = 8'd0;
   logic                  req_final_byte = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [KindBits-1:0]   rsp_token_kind;
   logic [LineBits-1:0]   rsp_start_line;
   logic [ColumnBits-1:0] rsp_start_column;
   logic [OffsetBits-1:0] rsp_text_offset;
   logic [OffsetBits-1:0] rsp_text_length;
   logic                  rsp_last_of_run;

   token_scoreboard sb = new();
   logic [7:0] src_bytes[$];
   int  cycles = 0;
   int  bytes_sent = 0;
   int  sources_sent = 0;
   bit  quiet = 0;

   source_tokenizer DUT (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Count cycles and stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   // Check every accepted token
   always @(posedge clock) begin
      exp_token_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind = rsp_token_kind; got.line = rsp_start_line;
         got.column = rsp_start_column; got.offset = rsp_text_offset;
         got.length = rsp_text_length; got.last = rsp_last_of_run;
         sb.check_token(got);
      end
   end

   // Stall the token side for a random count before each token
   initial begin
      int n;
      while (reset) @(posedge clock);
      forever begin
         n = quiet ? 0 : $urandom_range(0, 14);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic fin);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_source_byte <= b;
      req_final_byte <= fin;
      do @(posedge clock); while (req_stall);
      sb.note_byte(b, fin);
      bytes_sent++;
   endtask

   // Send the collected bytes as one source, marking the last
   task automatic send_source();
      foreach (src_bytes[i]) send_byte(src_bytes[i], i == src_bytes.size() - 1);
      src_bytes.delete();
      sources_sent++;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) src_bytes.push_back(s[i]);
   endtask

   // Drop valid and wait until every predicted token has come
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_tokens.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Append one random lexical fragment; the last one may leave a string open
   task automatic add_fragment(input bit last_one);
      string singles, pairs, alnum;
      logic [7:0] c;
      int n;
      singles = "#@?:\\!&^~%|(){}[],;+-*/=<>.$";
      pairs = ":=>>==!=<=>=&&||<<";
      alnum = "abcxyzABCXYZ_0123456789";
      case ($urandom_range(0, 11))
         0: begin
            n = $urandom_range(0, 4);
            if (n == 0) add_text($urandom_range(0, 1) ? "T" : "F");
            else begin
               src_bytes.push_back(alnum[$urandom_range(0, 12)]);
               repeat (n - 1) src_bytes.push_back(alnum[$urandom_range(0, 22)]);
            end
         end
         1: begin
            src_bytes.push_back(8'("1" + $urandom_range(0, 8)));
            repeat ($urandom_range(0, 3)) src_bytes.push_back(8'("0" + $urandom_range(0, 9)));
            if ($urandom_range(0, 1)) begin
               add_text(".");
               repeat ($urandom_range(0, 3))
                  src_bytes.push_back(8'("0" + $urandom_range(0, 9)));
            end
         end
         2: begin
            add_text($urandom_range(0, 1) ? "0x" : "0X");
            repeat ($urandom_range(0, 4))
               src_bytes.push_back(alnum[$urandom_range(0, 1) ? $urandom_range(0, 2)
                                   : $urandom_range(13, 22)]);
         end
         3: case ($urandom_range(0, 2))
            0: add_text("0");
            1: add_text("07");
            default: add_text("0.25");
         endcase
         4: begin
            n = $urandom_range(0, 8);
            src_bytes.push_back(pairs[2*n]);
            src_bytes.push_back(pairs[2*n+1]);
         end
         5: src_bytes.push_back(singles[$urandom_range(0, singles.len() - 1)]);
         6: begin
            add_text("\"");
            repeat ($urandom_range(0, 6)) begin
               c = 8'($urandom_range(0, 255));
               if (c == "\"" || c == "\\") add_text("\\");
               src_bytes.push_back(c);
               if ($urandom_range(0, 7) == 0) add_text("\\\"");
            end
            if (!(last_one && $urandom_range(0, 1))) add_text("\"");
         end
         7: begin
            add_text("//");
            repeat ($urandom_range(0, 6)) begin
               c = 8'($urandom_range(0, 255));
               if (c == "\n") c = 8'hff;
               src_bytes.push_back(c);
            end
            add_text("\n");
         end
         8: add_text("\n");
         9: case ($urandom_range(0, 2))
            0: add_text(" ");
            1: add_text("\t");
            default: src_bytes.push_back(8'h0d);
         endcase
         10: add_text($urandom_range(0, 1) ? "{\n" : ",\n");
         default: add_text(";");
      endcase
   endtask

   initial begin
      int frags;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: pairs, hex, float, comment, escaped quote, boolean, brace newline
      add_text("a:=0x1F>=3.5//z\n\"q\\\"\"{\nF");
      send_source();
      add_text("07 T\n");
      send_source();

      // Hold the sender until every predicted token has been seen
      drain();

      // Random sources built from well-formed fragments
      while (bytes_sent < ByteTarget) begin
         quiet = ($urandom_range(0, 5) == 0);
         frags = $urandom_range(1, 8);
         for (int i = 0; i < frags; i++) add_fragment(i == frags - 1);
         send_source();
      end
      quiet = 0;

      // Finish with a bad byte, then bytes that the halted block drops
      send_byte(8'h80, 1'b0);
      send_byte("a", 1'b0);
      send_byte(8'h00, 1'b1);
      req_valid <= 1'b0;

      drain();
      repeat (8) @(posedge clock);
      $display("Sent %0d bytes in %0d sources; checked %0d tokens, ending with a lex error.",
               bytes_sent, sources_sent, sb.tokens_checked);
      if (sb.errors == 0 && sb.expected_tokens.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
